@@ rtl/core/assert_macros.svh @@
// Assertion macros for the path point generator RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset
`define PPG_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset
`define PPG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/ppg_pkg.sv @@
// Shared types, constants and tables of the path point generator
package ppg_pkg;

  localparam int COORD_BITS   = 16;
  localparam int FRAC_BITS    = 16;
  localparam int POINT_W      = 2 * COORD_BITS;
  localparam int FIN_W        = FRAC_BITS + 2;
  localparam int S_W          = FRAC_BITS + 1;
  localparam int LEN_W        = 38;
  localparam int VEC_W        = 38;
  localparam int ANG_W        = 34;
  localparam int CORDIC_STEPS = 24;
  localparam int DIV_STEPS    = FRAC_BITS;
  localparam int SQRT_STEPS   = 32 + FRAC_BITS;
  localparam int GAIN_BITS    = 24;
  localparam logic [GAIN_BITS-1:0] CORDIC_GAIN = 24'd10188014;
  localparam logic [S_W-1:0] FRAC_ONE = S_W'(1) << FRAC_BITS;

  // Path modes
  localparam logic [2:0] MODE_LINE     = 3'd0;
  localparam logic [2:0] MODE_PARABOLA = 3'd1;
  localparam logic [2:0] MODE_TRIANGLE = 3'd2;
  localparam logic [2:0] MODE_RECT     = 3'd3;
  localparam logic [2:0] MODE_CIRCLE   = 3'd4;

  // Register indexes
  localparam logic [2:0] REG_MODE   = 3'd0;
  localparam logic [2:0] REG_SCALE  = 3'd1;
  localparam logic [2:0] REG_START  = 3'd2;
  localparam logic [2:0] REG_SECOND = 3'd3;
  localparam logic [2:0] REG_THIRD  = 3'd4;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  // Static path description seen by the back end
  typedef struct packed {
    logic [2:0]       mode;
    logic [S_W-1:0]   scale;
    coord_t           ax;
    coord_t           ay;
    coord_t           bx;
    coord_t           by;
    coord_t           cx;
    coord_t           cy;
    logic [LEN_W-1:0] l0;
    logic [LEN_W-1:0] l1;
    logic [LEN_W-1:0] l2;
    logic [LEN_W-1:0] l3;
    logic [LEN_W-1:0] c1;
    logic [LEN_W-1:0] c2;
    logic [LEN_W-1:0] c3;
    logic [LEN_W-1:0] per;
  } geom_t;

  // Classified item passed from front to back
  typedef struct packed {
    logic           rng;
    logic [S_W-1:0] s;
  } item_t;

  // Rotation angles in units of 2^-32 turn
  function automatic logic [31:0] turn_angle(input logic [4:0] i);
    logic [31:0] a;
    case (i)
      5'd0:  a = 32'd536870912;
      5'd1:  a = 32'd316933406;
      5'd2:  a = 32'd167458907;
      5'd3:  a = 32'd85004756;
      5'd4:  a = 32'd42667331;
      5'd5:  a = 32'd21354465;
      5'd6:  a = 32'd10679838;
      5'd7:  a = 32'd5340245;
      5'd8:  a = 32'd2670163;
      5'd9:  a = 32'd1335087;
      5'd10: a = 32'd667544;
      5'd11: a = 32'd333772;
      5'd12: a = 32'd166886;
      5'd13: a = 32'd83443;
      5'd14: a = 32'd41722;
      5'd15: a = 32'd20861;
      5'd16: a = 32'd10430;
      5'd17: a = 32'd5215;
      5'd18: a = 32'd2608;
      5'd19: a = 32'd1304;
      5'd20: a = 32'd652;
      5'd21: a = 32'd326;
      5'd22: a = 32'd163;
      5'd23: a = 32'd81;
      default: a = 32'd0;
    endcase
    return a;
  endfunction

endpackage

@@ rtl/core/ppg_geom.sv @@
// Configuration registers and iterative segment length unit
module ppg_geom (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_write,
  input  logic [2:0]              cfg_index,
  input  logic [ppg_pkg::POINT_W-1:0] cfg_data,
  output ppg_pkg::geom_t          geom,
  output logic                    busy
);
  import ppg_pkg::*;

  localparam logic [1:0] G_IDLE = 2'd0;
  localparam logic [1:0] G_LOAD = 2'd1;
  localparam logic [1:0] G_STEP = 2'd2;
  localparam logic [1:0] G_DONE = 2'd3;

  logic [2:0]         mode;
  logic [S_W-1:0]     scale;
  logic [POINT_W-1:0] sp;
  logic [POINT_W-1:0] bp;
  logic [POINT_W-1:0] tp;
  logic [1:0]         gst;
  logic [1:0]         seg;
  logic [5:0]         step;
  logic [63:0]        nsh;
  logic [39:0]        rem;
  logic [39:0]        root;
  logic [LEN_W-1:0]   lab;
  logic [LEN_W-1:0]   lbc;
  logic [LEN_W-1:0]   lca;

  coord_t ax, ay, bx, by, cx, cy;
  assign ax = sp[POINT_W-1:COORD_BITS];
  assign ay = sp[COORD_BITS-1:0];
  assign bx = bp[POINT_W-1:COORD_BITS];
  assign by = bp[COORD_BITS-1:0];
  assign cx = tp[POINT_W-1:COORD_BITS];
  assign cy = tp[COORD_BITS-1:0];

  // Squared length of the segment picked by seg
  coord_t px0, py0, px1, py1;
  logic signed [COORD_BITS:0] dx, dy;
  logic [35:0] nsq;
  always_comb begin
    case (seg)
      2'd0: begin
        px0 = ax; py0 = ay; px1 = bx; py1 = by;
      end
      2'd1: begin
        px0 = bx; py0 = by; px1 = cx; py1 = cy;
      end
      default: begin
        px0 = cx; py0 = cy; px1 = ax; py1 = ay;
      end
    endcase
    dx  = (COORD_BITS+1)'(px1) - (COORD_BITS+1)'(px0);
    dy  = (COORD_BITS+1)'(py1) - (COORD_BITS+1)'(py0);
    nsq = 36'($unsigned(36'(dx * dx))) + 36'($unsigned(36'(dy * dy)));
  end

  // One root bit per cycle
  logic [39:0] rem_s, trial, rem_n, root_n;
  logic        ge;
  always_comb begin
    rem_s  = {rem[37:0], nsh[63:62]};
    trial  = {root[37:0], 2'b01};
    ge     = rem_s >= trial;
    rem_n  = ge ? rem_s - trial : rem_s;
    root_n = {root[38:0], ge};
  end

  // Hold registers, run the length sequencer, restart it on any write
  always_ff @(posedge clk) begin
    if (rst) begin
      mode  <= MODE_LINE;
      scale <= FRAC_ONE;
      sp    <= '0;
      bp    <= '0;
      tp    <= '0;
      gst   <= G_IDLE;
      seg   <= '0;
      step  <= '0;
      lab   <= '0;
      lbc   <= '0;
      lca   <= '0;
    end else begin
      case (gst)
        G_LOAD: begin
          nsh  <= 64'(nsq);
          rem  <= '0;
          root <= '0;
          step <= '0;
          gst  <= G_STEP;
        end
        G_STEP: begin
          nsh  <= nsh << 2;
          rem  <= rem_n;
          root <= root_n;
          step <= step + 6'd1;
          if (step == 6'(SQRT_STEPS - 1)) begin
            case (seg)
              2'd0:    lab <= root_n[LEN_W-1:0];
              2'd1:    lbc <= root_n[LEN_W-1:0];
              default: lca <= root_n[LEN_W-1:0];
            endcase
            if (seg == 2'd2) begin
              gst <= G_DONE;
            end else begin
              seg <= seg + 2'd1;
              gst <= G_LOAD;
            end
          end
        end
        G_DONE: gst <= G_IDLE;
        default: gst <= G_IDLE;
      endcase
      if (cfg_write) begin
        case (cfg_index)
          REG_MODE:   mode  <= cfg_data[2:0];
          REG_SCALE:  scale <= cfg_data[S_W-1:0];
          REG_START:  sp    <= cfg_data;
          REG_SECOND: bp    <= cfg_data;
          REG_THIRD:  tp    <= cfg_data;
          default: ;
        endcase
        gst <= G_LOAD;
        seg <= '0;
      end
    end
  end

  assign busy = (gst != G_IDLE);

  // Derive segment table for the selected path
  logic signed [COORD_BITS:0] dw, dh;
  logic [COORD_BITS:0]        aw, ah;
  geom_t                      gn;
  always_comb begin
    dw = (COORD_BITS+1)'(bx) - (COORD_BITS+1)'(ax);
    dh = (COORD_BITS+1)'(by) - (COORD_BITS+1)'(ay);
    aw = dw[COORD_BITS] ? $unsigned(-dw) : $unsigned(dw);
    ah = dh[COORD_BITS] ? $unsigned(-dh) : $unsigned(dh);
    gn.mode  = mode;
    gn.scale = scale;
    gn.ax = ax; gn.ay = ay;
    gn.bx = bx; gn.by = by;
    gn.cx = cx; gn.cy = cy;
    if (mode == MODE_RECT) begin
      gn.l0 = LEN_W'(aw) << FRAC_BITS;
      gn.l1 = LEN_W'(ah) << FRAC_BITS;
      gn.l2 = LEN_W'(aw) << FRAC_BITS;
      gn.l3 = LEN_W'(ah) << FRAC_BITS;
    end else begin
      gn.l0 = lab;
      gn.l1 = lbc;
      gn.l2 = lca;
      gn.l3 = '0;
    end
    gn.c1  = gn.l0;
    gn.c2  = gn.l0 + gn.l1;
    gn.c3  = gn.c2 + gn.l2;
    gn.per = gn.c3 + gn.l3;
  end

  always_ff @(posedge clk) begin
    geom <= gn;
  end

endmodule

@@ rtl/core/ppg_front.sv @@
// Front end: range check and fraction scaling
module ppg_front (
  input  logic                       clk,
  input  logic                       rst,
  input  logic signed [ppg_pkg::FIN_W-1:0] fraction,
  input  logic                       item_valid,
  output logic                       item_stall,
  input  logic                       busy,
  input  logic [ppg_pkg::S_W-1:0]    scale,
  input  logic                       q_full,
  output logic                       push,
  output ppg_pkg::item_t             push_item
);
  import ppg_pkg::*;

  logic                 fvalid;
  item_t                fitem;
  logic                 rng;
  logic [S_W-1:0]       sc;
  logic [2*S_W-1:0]     prod;
  logic                 accept;

  // Classify and scale the incoming fraction
  always_comb begin
    rng  = !fraction[FIN_W-1] && (fraction <= $signed(FIN_W'(FRAC_ONE)));
    sc   = (scale > FRAC_ONE) ? FRAC_ONE : scale;
    prod = (2*S_W)'(fraction[S_W-1:0]) * (2*S_W)'(sc);
  end

  assign item_stall = busy || (fvalid && q_full);
  assign accept     = item_valid && !item_stall;
  assign push       = fvalid && !q_full;
  assign push_item  = fitem;

  // Hold one transaction until the queue takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      fvalid <= 1'b0;
    end else begin
      fvalid <= accept || (fvalid && q_full);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      fitem.rng <= rng;
      fitem.s   <= rng ? prod[S_W+FRAC_BITS-1:FRAC_BITS] : '0;
    end
  end

endmodule

@@ rtl/core/ppg_queue.sv @@
// Two-entry queue between front and back ends
`include "assert_macros.svh"
module ppg_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  ppg_pkg::item_t push_item,
  output logic           full,
  input  logic           pop,
  output ppg_pkg::item_t pop_item,
  output logic           nonempty
);
  import ppg_pkg::*;

  item_t      mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full     = (count == 2'd2);
  assign nonempty = (count != 2'd0);
  assign pop_item = mem[rd_ptr];

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop)  rd_ptr <= !rd_ptr;
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_item;
  end

  `PPG_ASSERT_IMPLY(a_no_overflow, push, !full, "queue push while full")
  `PPG_ASSERT_IMPLY(a_no_underflow, pop, nonempty, "queue pop while empty")
  `PPG_ASSERT_NEXT(a_push_counts, push && !pop, count == $past(count) + 2'd1, "queue count slip")

endmodule

@@ rtl/core/ppg_back.sv @@
// Back end: segment walk, divider, rotation and output pipeline
module ppg_back (
  input  logic                          clk,
  input  logic                          rst,
  input  ppg_pkg::geom_t                geom,
  input  ppg_pkg::item_t                q_item,
  input  logic                          q_valid,
  output logic                          q_pop,
  output logic signed [ppg_pkg::COORD_BITS-1:0] point_x,
  output logic signed [ppg_pkg::COORD_BITS-1:0] point_y,
  output logic                          in_range,
  output logic                          result_valid,
  input  logic                          result_stall
);
  import ppg_pkg::*;

  localparam int ITER0   = 3;
  localparam int ST_GAIN = ITER0 + CORDIC_STEPS;
  localparam int ST_SUM  = ST_GAIN + 1;
  localparam int ST_OUT  = ST_SUM + 1;
  localparam int NST     = ST_OUT + 1;

  localparam logic [1:0] DIV_RUN  = 2'd0;
  localparam logic [1:0] DIV_ONE  = 2'd1;
  localparam logic [1:0] DIV_ZERO = 2'd2;

  typedef struct packed {
    logic                    rng;
    logic [2:0]              mode;
    logic [S_W-1:0]          s;
    logic [S_W-1:0]          fy;
    logic [38:0]             phi;
    logic [32:0]             plo;
    logic [2*S_W-1:0]        s2;
    logic [LEN_W-1:0]        len;
    logic [1:0]              seg;
    logic [1:0]              dmode;
    logic [LEN_W-1:0]        rem;
    logic [LEN_W-1:0]        den;
    logic [S_W-1:0]          fq;
    logic signed [VEC_W-1:0] vx;
    logic signed [VEC_W-1:0] vy;
    logic signed [ANG_W-1:0] z;
    logic [37:0]             gxh;
    logic [47:0]             gxl;
    logic [37:0]             gyh;
    logic [47:0]             gyl;
    logic                    gxn;
    logic                    gyn;
    logic signed [34:0]      lpx;
    logic signed [34:0]      lpy;
    coord_t                  pax;
    coord_t                  pay;
    logic signed [39:0]      qx;
    logic signed [39:0]      qy;
    coord_t                  ox;
    coord_t                  oy;
  } pipe_t;

  pipe_t st [NST];
  pipe_t nx [NST];
  logic  vl [NST];
  logic  en;

  // Whole pipeline advances unless the output transaction is stalled
  assign en    = !vl[NST-1] || !result_stall;
  assign q_pop = en && q_valid;

  // Stage 0: perimeter products, square, quarter-turn rotation
  logic signed [COORD_BITS:0] ex, ey;
  logic signed [VEC_W-1:0]    evx, evy;
  always_comb begin
    nx[0]      = '0;
    nx[0].rng  = q_item.rng;
    nx[0].mode = geom.mode;
    nx[0].s    = q_item.s;
    nx[0].phi  = 39'(geom.per[LEN_W-1:FRAC_BITS]) * 39'(q_item.s);
    nx[0].plo  = 33'(geom.per[FRAC_BITS-1:0]) * 33'(q_item.s);
    nx[0].s2   = (2*S_W)'(q_item.s) * (2*S_W)'(q_item.s);
    ex  = (COORD_BITS+1)'(geom.ax) - (COORD_BITS+1)'(geom.bx);
    ey  = (COORD_BITS+1)'(geom.ay) - (COORD_BITS+1)'(geom.by);
    evx = VEC_W'(ex) <<< FRAC_BITS;
    evy = VEC_W'(ey) <<< FRAC_BITS;
    case (q_item.s[FRAC_BITS-1:FRAC_BITS-2])
      2'd0: begin nx[0].vx = evx;  nx[0].vy = evy;  end
      2'd1: begin nx[0].vx = -evy; nx[0].vy = evx;  end
      2'd2: begin nx[0].vx = -evx; nx[0].vy = -evy; end
      default: begin nx[0].vx = evy; nx[0].vy = -evx; end
    endcase
    nx[0].z = $signed(ANG_W'({q_item.s[FRAC_BITS-3:0], 16'b0}) << (32 - FRAC_BITS - 16));
  end

  // Stage 1: distance along perimeter and parabola fraction
  always_comb begin
    nx[1]     = st[0];
    nx[1].len = LEN_W'(st[0].phi + 39'(st[0].plo >> FRAC_BITS));
    nx[1].fy  = S_W'(st[0].s2 >> FRAC_BITS);
  end

  // Stage 2: pick the segment and set up the division
  logic [LEN_W-1:0] num;
  always_comb begin
    nx[2]     = st[1];
    num       = '0;
    nx[2].den = '0;
    nx[2].seg = 2'd0;
    case (st[1].mode)
      MODE_TRIANGLE, MODE_RECT: begin
        if (st[1].len <= geom.c1) begin
          nx[2].seg = 2'd0; num = st[1].len;           nx[2].den = geom.l0;
        end else if (st[1].len <= geom.c2) begin
          nx[2].seg = 2'd1; num = st[1].len - geom.c1; nx[2].den = geom.l1;
        end else if (st[1].mode == MODE_TRIANGLE || st[1].len <= geom.c3) begin
          nx[2].seg = 2'd2; num = st[1].len - geom.c2; nx[2].den = geom.l2;
        end else begin
          nx[2].seg = 2'd3; num = st[1].len - geom.c3; nx[2].den = geom.l3;
        end
      end
      default: ;
    endcase
    if (nx[2].den == '0) begin
      nx[2].dmode = DIV_ZERO;
    end else if (num >= nx[2].den) begin
      nx[2].dmode = DIV_ONE;
    end else begin
      nx[2].dmode = DIV_RUN;
    end
    nx[2].rem = num;
    nx[2].fq  = '0;
  end

  // Iteration stages: one rotation step each, and one quotient bit in each of the first DIV_STEPS
  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_iter
    logic [LEN_W-1:0]        r2;
    logic signed [VEC_W-1:0] ddx, ddy;
    logic signed [ANG_W-1:0] zt;
    always_comb begin
      nx[ITER0+i] = st[ITER0+i-1];
      r2 = {st[ITER0+i-1].rem[LEN_W-2:0], 1'b0};
      if (i < DIV_STEPS) begin
        if (r2 >= st[ITER0+i-1].den) begin
          nx[ITER0+i].rem = r2 - st[ITER0+i-1].den;
          nx[ITER0+i].fq  = {st[ITER0+i-1].fq[S_W-2:0], 1'b1};
        end else begin
          nx[ITER0+i].rem = r2;
          nx[ITER0+i].fq  = {st[ITER0+i-1].fq[S_W-2:0], 1'b0};
        end
      end
      ddx = st[ITER0+i-1].vy >>> i;
      ddy = st[ITER0+i-1].vx >>> i;
      zt  = $signed(ANG_W'(turn_angle(5'(i))));
      if (st[ITER0+i-1].z >= 0) begin
        nx[ITER0+i].vx = st[ITER0+i-1].vx - ddx;
        nx[ITER0+i].vy = st[ITER0+i-1].vy + ddy;
        nx[ITER0+i].z  = st[ITER0+i-1].z - zt;
      end else begin
        nx[ITER0+i].vx = st[ITER0+i-1].vx + ddx;
        nx[ITER0+i].vy = st[ITER0+i-1].vy - ddy;
        nx[ITER0+i].z  = st[ITER0+i-1].z + zt;
      end
    end
  end

  // Gain stage: scale rotated vector, form interpolation products
  logic [VEC_W-1:0]           mx, my;
  logic [S_W-1:0]             ffin, fxs, fys;
  coord_t                     qax, qay, qbx, qby;
  logic signed [COORD_BITS:0] dlx, dly;
  always_comb begin
    nx[ST_GAIN] = st[ST_GAIN-1];
    mx = st[ST_GAIN-1].vx[VEC_W-1] ? $unsigned(-st[ST_GAIN-1].vx) : $unsigned(st[ST_GAIN-1].vx);
    my = st[ST_GAIN-1].vy[VEC_W-1] ? $unsigned(-st[ST_GAIN-1].vy) : $unsigned(st[ST_GAIN-1].vy);
    nx[ST_GAIN].gxh = 38'(mx[VEC_W-1:GAIN_BITS]) * 38'(CORDIC_GAIN);
    nx[ST_GAIN].gxl = 48'(mx[GAIN_BITS-1:0]) * 48'(CORDIC_GAIN);
    nx[ST_GAIN].gyh = 38'(my[VEC_W-1:GAIN_BITS]) * 38'(CORDIC_GAIN);
    nx[ST_GAIN].gyl = 48'(my[GAIN_BITS-1:0]) * 48'(CORDIC_GAIN);
    nx[ST_GAIN].gxn = st[ST_GAIN-1].vx[VEC_W-1];
    nx[ST_GAIN].gyn = st[ST_GAIN-1].vy[VEC_W-1];
    case (st[ST_GAIN-1].dmode)
      DIV_ONE:  ffin = FRAC_ONE;
      DIV_ZERO: ffin = '0;
      default:  ffin = st[ST_GAIN-1].fq;
    endcase
    qax = geom.ax; qay = geom.ay; qbx = geom.ax; qby = geom.ay;
    fxs = '0;      fys = '0;
    case (st[ST_GAIN-1].mode)
      MODE_LINE: begin
        qbx = geom.bx; qby = geom.by;
        fxs = st[ST_GAIN-1].s; fys = st[ST_GAIN-1].s;
      end
      MODE_PARABOLA: begin
        qbx = geom.bx; qby = geom.by;
        fxs = st[ST_GAIN-1].s; fys = st[ST_GAIN-1].fy;
      end
      MODE_TRIANGLE: begin
        fxs = ffin; fys = ffin;
        case (st[ST_GAIN-1].seg)
          2'd0: begin qbx = geom.bx; qby = geom.by; end
          2'd1: begin
            qax = geom.bx; qay = geom.by; qbx = geom.cx; qby = geom.cy;
          end
          default: begin qax = geom.cx; qay = geom.cy; end
        endcase
      end
      MODE_RECT: begin
        fxs = ffin; fys = ffin;
        case (st[ST_GAIN-1].seg)
          2'd0: begin qbx = geom.bx; end
          2'd1: begin
            qax = geom.bx; qbx = geom.bx; qby = geom.by;
          end
          2'd2: begin
            qax = geom.bx; qay = geom.by; qby = geom.by;
          end
          default: begin qay = geom.by; end
        endcase
      end
      default: ;
    endcase
    dlx = (COORD_BITS+1)'(qbx) - (COORD_BITS+1)'(qax);
    dly = (COORD_BITS+1)'(qby) - (COORD_BITS+1)'(qay);
    nx[ST_GAIN].lpx = 35'(dlx) * $signed(35'(fxs));
    nx[ST_GAIN].lpy = 35'(dly) * $signed(35'(fys));
    nx[ST_GAIN].pax = qax;
    nx[ST_GAIN].pay = qay;
  end

  // Sum stage: add back the base point or the centre
  logic [37:0]        rxm, rym;
  logic signed [39:0] vxg, vyg;
  always_comb begin
    nx[ST_SUM] = st[ST_SUM-1];
    rxm = st[ST_SUM-1].gxh + 38'(st[ST_SUM-1].gxl >> GAIN_BITS);
    rym = st[ST_SUM-1].gyh + 38'(st[ST_SUM-1].gyl >> GAIN_BITS);
    vxg = st[ST_SUM-1].gxn ? -$signed(40'(rxm)) : $signed(40'(rxm));
    vyg = st[ST_SUM-1].gyn ? -$signed(40'(rym)) : $signed(40'(rym));
    if (st[ST_SUM-1].mode == MODE_CIRCLE) begin
      nx[ST_SUM].qx = (40'(geom.bx) <<< FRAC_BITS) + vxg;
      nx[ST_SUM].qy = (40'(geom.by) <<< FRAC_BITS) + vyg;
    end else begin
      nx[ST_SUM].qx = (40'(st[ST_SUM-1].pax) <<< FRAC_BITS) + 40'(st[ST_SUM-1].lpx);
      nx[ST_SUM].qy = (40'(st[ST_SUM-1].pay) <<< FRAC_BITS) + 40'(st[ST_SUM-1].lpy);
    end
  end

  // Output stage: truncate toward zero, saturate, zero the coordinates of out-of-range points
  localparam logic signed [39:0] ROUND_UP = 40'sd65535;
  localparam logic signed [39:0] SAT_HI   = 40'sd32767;
  localparam logic signed [39:0] SAT_LO   = -40'sd32768;
  logic signed [39:0] tx, ty;
  always_comb begin
    nx[ST_OUT] = st[ST_OUT-1];
    tx = (st[ST_OUT-1].qx < 0) ? (st[ST_OUT-1].qx + ROUND_UP) >>> FRAC_BITS
                               : st[ST_OUT-1].qx >>> FRAC_BITS;
    ty = (st[ST_OUT-1].qy < 0) ? (st[ST_OUT-1].qy + ROUND_UP) >>> FRAC_BITS
                               : st[ST_OUT-1].qy >>> FRAC_BITS;
    if (tx > SAT_HI)      tx = SAT_HI;
    else if (tx < SAT_LO) tx = SAT_LO;
    if (ty > SAT_HI)      ty = SAT_HI;
    else if (ty < SAT_LO) ty = SAT_LO;
    nx[ST_OUT].ox = st[ST_OUT-1].rng ? COORD_BITS'(tx) : '0;
    nx[ST_OUT].oy = st[ST_OUT-1].rng ? COORD_BITS'(ty) : '0;
  end

  // Advance valid bits and payload together
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NST; k++) vl[k] <= 1'b0;
    end else if (en) begin
      vl[0] <= q_valid;
      for (int k = 1; k < NST; k++) vl[k] <= vl[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < NST; k++) st[k] <= nx[k];
    end
  end

  assign result_valid = vl[NST-1];
  assign point_x      = st[NST-1].ox;
  assign point_y      = st[NST-1].oy;
  assign in_range     = st[NST-1].rng;

endmodule

@@ rtl/core/path_point_generator_top.sv @@
// Top level of the path point generator
// Takes one fraction per cycle while item_stall is low and returns one point per cycle while
// result_stall is low. A result passes through a front register, a two-entry queue and a
// 30-stage back pipeline whose length is set by the 24-step rotation unit (the 16-step
// divider for the segment fraction runs alongside it). Any write to a
// configuration register restarts the shared square-root unit, which rebuilds the
// three triangle side lengths one root bit per cycle; while it runs after a write,
// item_stall stays high. The user must write configuration only while no transaction
// is in flight; the block itself does not enforce this.
module path_point_generator_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [2:0]                    cfg_index,
  input  logic [ppg_pkg::POINT_W-1:0]   cfg_data,
  input  logic signed [ppg_pkg::FIN_W-1:0] fraction,
  input  logic                          item_valid,
  output logic                          item_stall,
  output logic signed [ppg_pkg::COORD_BITS-1:0] point_x,
  output logic signed [ppg_pkg::COORD_BITS-1:0] point_y,
  output logic                          in_range,
  output logic                          result_valid,
  input  logic                          result_stall
);
  import ppg_pkg::*;

  geom_t geom;
  logic  busy;
  logic  push;
  item_t push_item;
  logic  q_full;
  logic  q_pop;
  item_t q_item;
  logic  q_valid;

  ppg_geom u_geom (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .geom      (geom),
    .busy      (busy)
  );

  ppg_front u_front (
    .clk        (clk),
    .rst        (rst),
    .fraction   (fraction),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .busy       (busy),
    .scale      (geom.scale),
    .q_full     (q_full),
    .push       (push),
    .push_item  (push_item)
  );

  ppg_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (q_pop),
    .pop_item  (q_item),
    .nonempty  (q_valid)
  );

  ppg_back u_back (
    .clk          (clk),
    .rst          (rst),
    .geom         (geom),
    .q_item       (q_item),
    .q_valid      (q_valid),
    .q_pop        (q_pop),
    .point_x      (point_x),
    .point_y      (point_y),
    .in_range     (in_range),
    .result_valid (result_valid),
    .result_stall (result_stall)
  );

endmodule

@@ dv/testbench.sv @@
// Testbench for the path point generator: random and directed fractions, checked on a scoreboard
`timescale 1ns / 100ps

module testbench;
  import ppg_pkg::*;

  localparam int IDLE_LIMIT  = 3000;
  localparam int DRAIN_WAIT  = 50;
  localparam int HOLD_CYCLES = 400;
  localparam int ITEM_TARGET = 700;

  typedef struct {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic               r;
  } point_res_t;

  // Tracks the register copy and the points still owed by the block
  class point_scoreboard;
    logic [2:0]  mode;
    logic [16:0] scale;
    logic [31:0] start_pt, second_pt, third_pt;
    point_res_t  pending_points[$];
    int          mismatches;

    function new();
      mode = MODE_LINE;
      scale = 17'h10000;
      start_pt = 0;
      second_pt = 0;
      third_pt = 0;
      mismatches = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [31:0] data);
      case (idx)
        REG_MODE:   mode = data[2:0];
        REG_SCALE:  scale = data[16:0];
        REG_START:  start_pt = data;
        REG_SECOND: second_pt = data;
        REG_THIRD:  third_pt = data;
        default: ;
      endcase
    endfunction

    function longint unsigned root_q(longint unsigned n);
      longint unsigned rem, root, trial, pair;
      rem = 0;
      root = 0;
      for (int i = 0; i < 48; i++) begin
        pair = (i < 32) ? ((n >> (62 - 2 * i)) & 64'd3) : 64'd0;
        rem = (rem << 2) | pair;
        trial = (root << 2) | 64'd1;
        if (rem >= trial) begin
          rem = rem - trial;
          root = (root << 1) | 64'd1;
        end else begin
          root = root << 1;
        end
      end
      return root;
    endfunction

    function longint unsigned side_len(longint ax, longint ay, longint bx, longint by);
      longint dx, dy;
      dx = bx - ax;
      dy = by - ay;
      return root_q(longint'(unsigned'(dx * dx)) + longint'(unsigned'(dy * dy)));
    endfunction

    function longint unsigned ratio(longint unsigned num, longint unsigned den);
      longint unsigned r, f;
      r = num;
      f = 0;
      if (den == 0) return 0;
      if (num >= den) return 64'd65536;
      for (int i = 0; i < 16; i++) begin
        r = r << 1;
        f = f << 1;
        if (r >= den) begin
          r = r - den;
          f = f | 64'd1;
        end
      end
      return f;
    endfunction

    function longint unsigned scale_by(longint unsigned a, longint unsigned s);
      return (a >> 16) * s + (((a & 64'hFFFF) * s) >> 16);
    endfunction

    function longint blend(longint a, longint b, longint unsigned f);
      longint q;
      q = a * 65536 + (b - a) * longint'(f);
      return q / 65536;
    endfunction

    function longint gain(longint v);
      longint unsigned m, r;
      m = (v < 0) ? -v : v;
      r = (m >> 24) * 64'd10188014 + (((m & 64'hFFFFFF) * 64'd10188014) >> 24);
      return (v < 0) ? -longint'(r) : longint'(r);
    endfunction

    function logic signed [15:0] clamp(longint v);
      if (v > 32767) return 16'sh7FFF;
      if (v < -32768) return 16'sh8000;
      return v[15:0];
    endfunction

    // Walk a polygon of up to four corners by perimeter length
    function void walk(longint px[4], longint py[4], longint unsigned sl[4], int n,
                       longint unsigned s, output longint ox, output longint oy);
      longint unsigned per, len, acc;
      per = 0;
      for (int i = 0; i < n; i++) per += sl[i];
      ox = px[0];
      oy = py[0];
      if (per == 0) return;
      len = scale_by(per, s);
      acc = 0;
      for (int i = 0; i < n; i++) begin
        if (len <= acc + sl[i] || i == n - 1) begin
          ox = blend(px[i], px[(i + 1) % n], ratio(len - acc, sl[i]));
          oy = blend(py[i], py[(i + 1) % n], ratio(len - acc, sl[i]));
          return;
        end
        acc += sl[i];
      end
    endfunction

    function point_res_t predict(logic [17:0] frac);
      point_res_t res;
      longint t, ax, ay, bx, by, cx, cy, ox, oy, vx, vy, tmp, z, dx, dy;
      longint unsigned sc, s, q, w, h;
      longint px[4], py[4];
      longint unsigned sl[4];
      t = longint'($signed(frac));
      res.x = 0;
      res.y = 0;
      res.r = 0;
      if (t < 0 || t > 65536) return res;
      sc = (scale > 17'h10000) ? 64'd65536 : longint'(scale);
      s = scale_by(t, sc);
      ax = longint'($signed(start_pt[31:16]));
      ay = longint'($signed(start_pt[15:0]));
      bx = longint'($signed(second_pt[31:16]));
      by = longint'($signed(second_pt[15:0]));
      cx = longint'($signed(third_pt[31:16]));
      cy = longint'($signed(third_pt[15:0]));
      case (mode)
        MODE_LINE: begin
          ox = blend(ax, bx, s);
          oy = blend(ay, by, s);
        end
        MODE_PARABOLA: begin
          ox = blend(ax, bx, s);
          oy = blend(ay, by, scale_by(s, s));
        end
        MODE_TRIANGLE: begin
          px = '{ax, bx, cx, 0};
          py = '{ay, by, cy, 0};
          sl = '{side_len(ax, ay, bx, by), side_len(bx, by, cx, cy),
                 side_len(cx, cy, ax, ay), 0};
          walk(px, py, sl, 3, s, ox, oy);
        end
        MODE_RECT: begin
          w = ((bx > ax) ? bx - ax : ax - bx) << 16;
          h = ((by > ay) ? by - ay : ay - by) << 16;
          px = '{ax, bx, bx, ax};
          py = '{ay, ay, by, by};
          sl = '{w, h, w, h};
          walk(px, py, sl, 4, s, ox, oy);
        end
        MODE_CIRCLE: begin
          vx = (ax - bx) * 65536;
          vy = (ay - by) * 65536;
          q = (s >> 14) & 64'd3;
          for (int k = 0; k < q; k++) begin
            tmp = vx;
            vx = -vy;
            vy = tmp;
          end
          z = longint'((s & 64'h3FFF) << 16);
          for (int i = 0; i < 24; i++) begin
            dx = vy >>> i;
            dy = vx >>> i;
            if (z >= 0) begin
              vx -= dx;
              vy += dy;
              z -= longint'(turn_angle(i[4:0]));
            end else begin
              vx += dx;
              vy -= dy;
              z += longint'(turn_angle(i[4:0]));
            end
          end
          ox = (bx * 65536 + gain(vx)) / 65536;
          oy = (by * 65536 + gain(vy)) / 65536;
        end
        default: begin
          ox = ax;
          oy = ay;
        end
      endcase
      res.x = clamp(ox);
      res.y = clamp(oy);
      res.r = 1;
      return res;
    endfunction

    function void note_fraction(logic [17:0] frac);
      pending_points.push_back(predict(frac));
    endfunction

    function void check_point(logic signed [15:0] x, logic signed [15:0] y, logic r);
      point_res_t e;
      if (pending_points.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected point x=%0d y=%0d r=%0b", x, y, r);
        return;
      end
      e = pending_points.pop_front();
      if (x !== e.x || y !== e.y || r !== e.r) begin
        mismatches++;
        if (mismatches <= 10)
          $display("point mismatch: expected x=%0d y=%0d r=%0b, got x=%0d y=%0d r=%0b",
                   e.x, e.y, e.r, x, y, r);
      end
    endfunction
  endclass

  logic               clk = 0;
  logic               rst;
  logic               cfg_write;
  logic [2:0]         cfg_index;
  logic [31:0]        cfg_data;
  logic signed [17:0] fraction;
  logic               item_valid;
  logic               item_stall;
  logic signed [15:0] point_x, point_y;
  logic               in_range;
  logic               result_valid;
  logic               result_stall;

  point_scoreboard sb = new();
  int  idle_cycles = 0;
  int  stall_left = 0;
  int  hold_left = 0;
  bit  hold_req = 0;
  bit  hold_done = 0;
  bit  sender_burst = 0;
  int  sent = 0;

  always #1 clk = ~clk;

  path_point_generator_top u_top (
    .clk(clk), .rst(rst), .cfg_write(cfg_write), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .fraction(fraction), .item_valid(item_valid),
    .item_stall(item_stall), .point_x(point_x), .point_y(point_y),
    .in_range(in_range), .result_valid(result_valid), .result_stall(result_stall)
  );

  function automatic int rand_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 4);
    return $urandom_range(10, 50);
  endfunction

  function automatic logic [31:0] rand_point();
    case ($urandom_range(0, 5))
      0: return 32'h7FFF_7FFF;
      1: return 32'h8000_8000;
      2: return {16'h7FFF, 16'h8000};
      3: return {16'($urandom_range(0, 200) - 100), 16'($urandom_range(0, 200) - 100)};
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [17:0] rand_fraction();
    case ($urandom_range(0, 19))
      0: return 18'h00000;
      1: return 18'h10000;
      2: return 18'($urandom);
      3: return 18'h10001 + 18'($urandom_range(0, 'h1FFFE - 'h10001));
      default: return 18'($urandom_range(0, 65536));
    endcase
  endfunction

  // Drain outstanding points, then apply one register write
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
    while (sb.pending_points.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_write <= 1'b0;
    sb.write_reg(idx, data);
  endtask

  // Offer one fraction and hold it until the block takes the transaction
  task automatic send_fraction(input logic [17:0] f);
    int gap;
    gap = sender_burst ? 0 : rand_gap();
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1'b1;
    fraction   <= f;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    sb.note_fraction(f);
    sent++;
  endtask

  task automatic end_burst();
    item_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Receiver: check accepted points and stall at random
  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall)
      sb.check_point(point_x, point_y, in_range);
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      result_stall <= 1'b1;
    end else if (hold_req && !hold_done) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES;
      result_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      result_stall <= 1'b1;
    end else begin
      result_stall <= 1'b0;
      if ($urandom_range(0, 99) < 20) stall_left <= rand_gap();
    end
  end

  // Watchdog on cycles with no transaction on either side
  always @(posedge clk) begin
    if ((item_valid && !item_stall) || (result_valid && !result_stall))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    logic [17:0] edge_fracs[5];
    int n;
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = REG_MODE;
    cfg_data = 0;
    fraction = 0;
    item_valid = 1'b0;
    result_stall = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: each path with extreme corners, ends of the fraction range
    edge_fracs = '{18'h00000, 18'h10000, 18'h08000, 18'h3FFFF, 18'h20000};
    for (int m = MODE_LINE; m <= MODE_CIRCLE; m++) begin
      write_reg(REG_MODE, 32'(m));
      write_reg(REG_SCALE, 32'h10000);
      write_reg(REG_START, (m % 2) ? 32'h8000_8000 : 32'h0000_0000);
      write_reg(REG_SECOND, 32'h7FFF_7FFF);
      write_reg(REG_THIRD, 32'h8000_7FFF);
      foreach (edge_fracs[i]) send_fraction(edge_fracs[i]);
      end_burst();
    end

    // Random phases: new settings, then a batch of fractions
    while (sent < ITEM_TARGET) begin
      write_reg(REG_MODE, ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 4));
      case ($urandom_range(0, 5))
        0: write_reg(REG_SCALE, 32'h0);
        1: write_reg(REG_SCALE, 32'h1FFFF);
        2: write_reg(REG_SCALE, $urandom);
        default: write_reg(REG_SCALE, 32'h10000 - $urandom_range(0, 32768));
      endcase
      write_reg(REG_START, rand_point());
      write_reg(REG_SECOND, ($urandom_range(0, 7) == 0) ? sb.start_pt : rand_point());
      write_reg(REG_THIRD, ($urandom_range(0, 7) == 0) ? sb.start_pt : rand_point());
      if ($urandom_range(0, 4) == 0) write_reg(3'($urandom_range(5, 7)), $urandom);
      sender_burst = ($urandom_range(0, 3) == 0);
      n = $urandom_range(15, 35);
      for (int i = 0; i < n; i++) begin
        if (sent > 300 && !hold_req) hold_req = 1;
        send_fraction(rand_fraction());
      end
      end_burst();
    end

    // Drain and settle
    while (sb.pending_points.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending_points.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+rtl/core
rtl/core/ppg_pkg.sv
rtl/core/ppg_geom.sv
rtl/core/ppg_front.sv
rtl/core/ppg_queue.sv
rtl/core/ppg_back.sv
rtl/core/path_point_generator_top.sv
dv/testbench.sv
